[hw/rtl/hte_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hte_pkg: shared types and constants for the HTML text escaper
// Holds the command word passed from classifier to expander, the character
// codes the classifier looks for and the entity spelling tables.
// ----------------------------------------------------------------------------
package hte_pkg;

    localparam int CHAR_WIDTH = 16;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);
    localparam int POS_W      = 3;   // position inside the longest entity (6 chars)
    localparam int UNITS_W    = 2;   // remaining space units minus one (tab gives 4)

    typedef logic [CHAR_WIDTH-1:0] char_t;

    localparam char_t CH_LT    = CHAR_WIDTH'(8'h3C);
    localparam char_t CH_GT    = CHAR_WIDTH'(8'h3E);
    localparam char_t CH_AMP   = CHAR_WIDTH'(8'h26);
    localparam char_t CH_LF    = CHAR_WIDTH'(8'h0A);
    localparam char_t CH_TAB   = CHAR_WIDTH'(8'h09);
    localparam char_t CH_SPACE = CHAR_WIDTH'(8'h20);

    localparam logic [UNITS_W-1:0] UNITS_ONE = UNITS_W'(0);
    localparam logic [UNITS_W-1:0] UNITS_TAB = UNITS_W'(3);

    // What the expander has to produce for one source character
    typedef enum logic [2:0] {
        K_PLAIN,
        K_LT,
        K_GT,
        K_AMP,
        K_BR,
        K_SPACE
    } kind_t;

    typedef struct packed {
        kind_t                kind;
        char_t                ch;
        logic [UNITS_W-1:0]   units;    // space units still to come after the first
        logic                 nb;       // first space unit is a non-breaking entity
    } cmd_t;

    // Position of the final character of each spelling
    function automatic logic [POS_W-1:0] last_pos(input kind_t kind);
        logic [POS_W-1:0] r;
        unique case (kind)
            K_LT:    r = POS_W'(3);
            K_GT:    r = POS_W'(3);
            K_AMP:   r = POS_W'(4);
            K_BR:    r = POS_W'(5);
            K_SPACE: r = POS_W'(5);
            default: r = POS_W'(0);
        endcase
        return r;
    endfunction

    // Character of a spelling at a given position; space kind spells the nbsp entity
    function automatic logic [7:0] glyph(input kind_t kind, input logic [POS_W-1:0] pos);
        logic [7:0] r;
        r = 8'h26;
        unique case (kind)
            K_LT:
                unique case (pos)
                    3'd0:    r = 8'h26;  // &
                    3'd1:    r = 8'h6C;  // l
                    3'd2:    r = 8'h74;  // t
                    default: r = 8'h3B;  // ;
                endcase
            K_GT:
                unique case (pos)
                    3'd0:    r = 8'h26;
                    3'd1:    r = 8'h67;  // g
                    3'd2:    r = 8'h74;
                    default: r = 8'h3B;
                endcase
            K_AMP:
                unique case (pos)
                    3'd0:    r = 8'h26;
                    3'd1:    r = 8'h61;  // a
                    3'd2:    r = 8'h6D;  // m
                    3'd3:    r = 8'h70;  // p
                    default: r = 8'h3B;
                endcase
            K_BR:
                unique case (pos)
                    3'd0:    r = 8'h3C;  // <
                    3'd1:    r = 8'h62;  // b
                    3'd2:    r = 8'h72;  // r
                    3'd3:    r = 8'h20;  // space
                    3'd4:    r = 8'h2F;  // /
                    default: r = 8'h3E;  // >
                endcase
            K_SPACE:
                unique case (pos)
                    3'd0:    r = 8'h26;
                    3'd1:    r = 8'h6E;  // n
                    3'd2:    r = 8'h62;  // b
                    3'd3:    r = 8'h73;  // s
                    3'd4:    r = 8'h70;  // p
                    default: r = 8'h3B;
                endcase
            default: r = 8'h26;
        endcase
        return r;
    endfunction

endpackage

[hw/rtl/hte_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hte_front: input classifier
// Accepts source words, decides how each one is spelt and tracks whether
// the last output character breaks spacing, then pushes a command word.
// ----------------------------------------------------------------------------
module hte_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_wr_en,
    input  logic           cfg_wr_data,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  hte_pkg::char_t s_tdata,   // [15:0] text_char
    input  logic           s_tuser,   // [0] text_start
    output logic           push,
    output hte_pkg::cmd_t  push_cmd,
    input  logic           q_full
);
    import hte_pkg::*;

    logic escape_whitespace_reg;
    logic prev_breaks_reg;
    logic prev_breaks_next;
    logic prev_in;

    assign s_tready = !q_full;
    assign push     = s_tvalid && s_tready;
    assign prev_in  = s_tuser || prev_breaks_reg;

    // Classify the word and work out the spacing flag it leaves behind
    always_comb
    begin
        push_cmd.kind  = K_PLAIN;
        push_cmd.ch    = s_tdata;
        push_cmd.units = UNITS_ONE;
        push_cmd.nb    = prev_in;
        prev_breaks_next = (s_tdata == CH_SPACE);
        priority if (s_tdata == CH_LT)
        begin
            push_cmd.kind    = K_LT;
            prev_breaks_next = 1'b0;
        end
        else if (s_tdata == CH_GT)
        begin
            push_cmd.kind    = K_GT;
            prev_breaks_next = 1'b0;
        end
        else if (s_tdata == CH_AMP)
        begin
            push_cmd.kind    = K_AMP;
            prev_breaks_next = 1'b0;
        end
        else if (escape_whitespace_reg && s_tdata == CH_LF)
        begin
            push_cmd.kind    = K_BR;
            prev_breaks_next = 1'b1;
        end
        else if (escape_whitespace_reg && s_tdata == CH_TAB)
        begin
            // four alternating units leave the flag as it was
            push_cmd.kind    = K_SPACE;
            push_cmd.units   = UNITS_TAB;
            prev_breaks_next = prev_in;
        end
        else if (escape_whitespace_reg && s_tdata == CH_SPACE)
        begin
            push_cmd.kind    = K_SPACE;
            prev_breaks_next = !prev_in;
        end
        else
        begin
            push_cmd.kind = K_PLAIN;
        end
    end

    // Hold configuration and spacing flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escape_whitespace_reg <= 1'b1;
            prev_breaks_reg       <= 1'b1;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                escape_whitespace_reg <= cfg_wr_data;
            end
            if (push)
            begin
                prev_breaks_reg <= prev_breaks_next;
            end
        end
    end

endmodule

[hw/rtl/hte_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hte_queue: command queue
// Short first-in first-out store of command words between classifier
// and expander.
// ----------------------------------------------------------------------------
module hte_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  hte_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output hte_pkg::cmd_t head,
    output logic          empty
);
    import hte_pkg::*;

    cmd_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign full  = (count_reg == QCNT_W'(QDEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    // Store pushed words
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

[hw/rtl/hte_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hte_back: expander
// Spells the command at the queue head into an output register, one character
// per cycle unless the receiver stalls, and pops it after its final character.
// ----------------------------------------------------------------------------
module hte_back (
    input  logic           clk,
    input  logic           rst_n,
    input  hte_pkg::cmd_t  head,
    input  logic           empty,
    output logic           pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output hte_pkg::char_t m_tdata,   // [15:0] out_char
    output logic           m_tlast    // last_of_run
);
    import hte_pkg::*;

    logic               busy_reg, busy_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [UNITS_W-1:0] units_reg, units_next;
    logic               nb_reg, nb_next;
    logic               out_valid_reg;
    char_t              out_char_reg;
    logic               out_last_reg;

    logic               adv;
    logic               fire;
    logic [POS_W-1:0]   eff_pos;
    logic [UNITS_W-1:0] eff_units;
    logic               eff_nb;
    char_t              cur_char;
    logic               unit_end;
    logic               done;

    assign adv       = !out_valid_reg || m_tready;
    assign fire      = adv && !empty;
    assign pop       = fire && done;
    assign eff_pos   = busy_reg ? pos_reg : '0;
    assign eff_units = busy_reg ? units_reg : head.units;
    assign eff_nb    = busy_reg ? nb_reg : head.nb;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tlast  = out_last_reg;

    // Pick the current character and decide where the spelling ends
    always_comb
    begin
        cur_char = head.ch;
        unit_end = 1'b1;
        done     = 1'b1;
        unique case (head.kind)
            K_PLAIN:
            begin
                cur_char = head.ch;
                done     = 1'b1;
            end
            K_SPACE:
            begin
                if (eff_nb)
                begin
                    cur_char = CHAR_WIDTH'(glyph(K_SPACE, eff_pos));
                    unit_end = (eff_pos == last_pos(K_SPACE));
                end
                else
                begin
                    cur_char = CH_SPACE;
                    unit_end = 1'b1;
                end
                done = unit_end && (eff_units == '0);
            end
            default:
            begin
                cur_char = CHAR_WIDTH'(glyph(head.kind, eff_pos));
                done     = (eff_pos == last_pos(head.kind));
            end
        endcase
    end

    // Advance the position within the command
    always_comb
    begin
        busy_next  = busy_reg;
        pos_next   = pos_reg;
        units_next = units_reg;
        nb_next    = nb_reg;
        if (fire)
        begin
            priority if (done)
            begin
                busy_next = 1'b0;
                pos_next  = '0;
            end
            else if (head.kind == K_SPACE && unit_end)
            begin
                busy_next  = 1'b1;
                pos_next   = '0;
                units_next = eff_units - UNITS_W'(1);
                nb_next    = !eff_nb;
            end
            else
            begin
                busy_next  = 1'b1;
                pos_next   = eff_pos + POS_W'(1);
                units_next = eff_units;
                nb_next    = eff_nb;
            end
        end
    end

    // Hold sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            pos_reg   <= '0;
            units_reg <= '0;
            nb_reg    <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            pos_reg   <= pos_next;
            units_reg <= units_next;
            nb_reg    <= nb_next;
        end
    end

    // Output register: load when empty or being taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= !empty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_char_reg <= cur_char;
            out_last_reg <= done;
        end
    end

endmodule

[hw/rtl/html_text_escape_stream.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// html_text_escape_stream: streaming HTML text escaper
// Turns source characters into their HTML spelling, one character per
// output word, with tlast on the final word of each source character.
//
//   Channel  Dir  tdata              tuser        tlast
//   s_*      in   [15:0] text_char   [0] text_start  -
//   m_*      out  [15:0] out_char    -            last_of_run
//   cfg_*    in   [0] escape_whitespace (write only, reset 1)
//
// Plain characters pass at one word per cycle while the expander is free and
// the receiver keeps up. A source character that expands to more than one
// output word holds the expander until its last word; the four-entry command
// queue keeps taking input meanwhile. An accepted word is written into the
// command queue, then spelt from there into the output register.
// Reset clears the queue and output register and sets the spacing flag.
// Either side may stall independently; the output register keeps its word.
// ----------------------------------------------------------------------------
module html_text_escape_stream (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_wr_en,
    input  logic           cfg_wr_data,  // [0] escape_whitespace
    input  logic           s_tvalid,
    output logic           s_tready,
    input  hte_pkg::char_t s_tdata,      // [15:0] text_char
    input  logic           s_tuser,      // [0] text_start
    output logic           m_tvalid,
    input  logic           m_tready,
    output hte_pkg::char_t m_tdata,      // [15:0] out_char
    output logic           m_tlast       // last_of_run
);
    import hte_pkg::*;

    logic push;
    cmd_t push_cmd;
    logic q_full;
    logic pop;
    cmd_t head;
    logic q_empty;

    hte_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .push        (push),
        .push_cmd    (push_cmd),
        .q_full      (q_full)
    );

    hte_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .head     (head),
        .empty    (q_empty)
    );

    hte_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .empty    (q_empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

[verif/hte_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hte_checker: scoreboard for the HTML text escaper
// Watches the configuration port and both stream channels. Every source
// word accepted on the input side is expanded into its expected HTML words,
// and every word accepted on the output side is compared against the oldest
// of them, character and tlast separately.
// ----------------------------------------------------------------------------
module hte_checker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_wr_en,
    input  logic           cfg_wr_data,
    input  logic           s_tvalid,
    input  logic           s_tready,
    input  hte_pkg::char_t s_tdata,
    input  logic           s_tuser,
    input  logic           m_tvalid,
    input  logic           m_tready,
    input  hte_pkg::char_t m_tdata,
    input  logic           m_tlast,
    output int unsigned    mismatches,
    output int unsigned    pending
);
    import hte_pkg::*;

    typedef struct packed {
        char_t ch;
        logic  last;
    } html_word_t;

    html_word_t html_due[$];
    logic       ws_escape    = 1'b1;
    logic       space_broken = 1'b1;

    // Append one expected output character, not yet marked as last
    function automatic void push_char(input char_t c);
        html_word_t w;
        w.ch   = c;
        w.last = 1'b0;
        html_due.insert(html_due.size(), w);
    endfunction

    function automatic void push_spelling(input string s);
        for (int i = 0; i < s.len(); i++)
            push_char(char_t'(s[i]));
    endfunction

    // Expand one source character into its HTML words and advance the spacing flag
    function automatic void expand_char(input char_t ch, input logic start);
        int units;
        if (start)
            space_broken = 1'b1;
        if (ch == CH_LT)
        begin
            push_spelling("&lt;");
            space_broken = 1'b0;
        end
        else if (ch == CH_GT)
        begin
            push_spelling("&gt;");
            space_broken = 1'b0;
        end
        else if (ch == CH_AMP)
        begin
            push_spelling("&amp;");
            space_broken = 1'b0;
        end
        else if (ws_escape && ch == CH_LF)
        begin
            push_spelling("<br />");
            space_broken = 1'b1;
        end
        else if (ws_escape && (ch == CH_TAB || ch == CH_SPACE))
        begin
            units = (ch == CH_TAB) ? 4 : 1;
            // each unit alternates between an entity and a plain space
            for (int i = 0; i < units; i++)
            begin
                if (space_broken)
                begin
                    push_spelling("&nbsp;");
                    space_broken = 1'b0;
                end
                else
                begin
                    push_char(CH_SPACE);
                    space_broken = 1'b1;
                end
            end
        end
        else
        begin
            push_char(ch);
            space_broken = (ch == CH_SPACE || ch == CH_GT);
        end
        html_due[html_due.size() - 1].last = 1'b1;
    endfunction

    always @(posedge clk)
    begin : watch
        html_word_t head;
        if (!rst_n)
        begin
            ws_escape    = 1'b1;
            space_broken = 1'b1;
            html_due.delete();
        end
        else
        begin
            // Compare an accepted output word with the oldest expectation
            if (m_tvalid && m_tready)
            begin
                if (html_due.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: word with nothing expected: expected none, got char %h last %b",
                             $time, m_tdata, m_tlast);
                end
                else
                begin
                    head = html_due.pop_front();
                    if (m_tdata !== head.ch)
                    begin
                        mismatches++;
                        $display("%0t: out_char mismatch: expected %h, got %h",
                                 $time, head.ch, m_tdata);
                    end
                    if (m_tlast !== head.last)
                    begin
                        mismatches++;
                        $display("%0t: last_of_run mismatch: expected %b, got %b",
                                 $time, head.last, m_tlast);
                    end
                end
            end
            // Track the register; writes must happen only while the block is idle, which the block does not enforce
            if (cfg_wr_en)
                ws_escape = cfg_wr_data;
            if (s_tvalid && s_tready)
                expand_char(s_tdata, s_tuser);
        end
        pending = html_due.size();
    end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the HTML text escaper
// Drives source characters with random gaps, a randomly stalling receiver
// and one long receiver hold-off that backs the block up. Runs a directed
// set of escape and spacing cases, then random texts under both register
// settings. The checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
    import hte_pkg::*;

    localparam int unsigned HOLD_CYCLES    = 300;
    localparam int unsigned WATCHDOG_LIMIT = 5000;
    localparam int unsigned DRAIN_CYCLES   = 8;

    logic  clk         = 1'b0;
    logic  rst_n       = 1'b0;
    logic  cfg_wr_en   = 1'b0;
    logic  cfg_wr_data = 1'b0;
    logic  s_tvalid    = 1'b0;
    logic  s_tready;
    char_t s_tdata     = '0;
    logic  s_tuser     = 1'b0;
    logic  m_tvalid;
    logic  m_tready    = 1'b0;
    char_t m_tdata;
    logic  m_tlast;

    int unsigned mismatches;
    int unsigned pending;
    int unsigned quiet_cycles = 0;
    int unsigned rx_hold      = 0;
    bit          rx_steady    = 1'b0;
    bit          tx_steady    = 1'b0;
    bit          squeeze_req  = 1'b0;
    bit          squeeze_done = 1'b0;

    always #6 clk = ~clk;

    html_text_escape_stream dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    hte_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .mismatches  (mismatches),
        .pending     (pending)
    );

    // Receiver: random stalls, stretches of steady acceptance, one long hold-off
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (rx_hold > 0)
        begin
            m_tready <= 1'b0;
            rx_hold  <= rx_hold - 1;
        end
        else if (squeeze_req && !squeeze_done)
        begin
            m_tready     <= 1'b0;
            rx_hold      <= HOLD_CYCLES - 1;
            squeeze_done <= 1'b1;
        end
        else if (!rx_steady && $urandom_range(99) < 25)
        begin
            m_tready <= 1'b0;
            rx_hold  <= ($urandom_range(9) == 0) ? $urandom_range(39, 10)
                                                 : $urandom_range(2, 0);
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog: give up when no word moves on either side for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (tx_steady || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(3, 1);
        else
            return $urandom_range(40, 8);
    endfunction

    // Offer one source word; entered and left at a falling edge, tvalid stays high
    task automatic send_char(input char_t ch, input logic start);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tuser  <= start;
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        @(negedge clk);
    endtask

    // Write the register once every expected word has come out
    task automatic write_escape(input logic on);
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= on;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic char_t pick_text_char();
        int unsigned r;
        char_t       specials [6];
        specials = '{CH_SPACE, CH_TAB, CH_LF, CH_LT, CH_GT, CH_AMP};
        r = $urandom_range(99);
        if (r < 10)
            return CH_SPACE;
        else if (r < 16)
            return CH_TAB;
        else if (r < 21)
            return CH_LF;
        else if (r < 26)
            return CH_LT;
        else if (r < 31)
            return CH_GT;
        else if (r < 35)
            return CH_AMP;
        else if (r < 70)
            return char_t'($urandom_range(16'h7E, 16'h21));
        else if (r < 88)
            return char_t'($urandom_range(16'hFFFF, 0));
        // special low byte under a non-zero high byte must pass unchanged
        return {8'($urandom_range(255, 1)), specials[$urandom_range(5)][7:0]};
    endfunction

    // Random texts: a start flag on each first word, stray starts now and then
    task automatic send_texts(input int unsigned n_items, input bit squeeze_midway);
        int unsigned sent;
        int unsigned text_left;
        logic        start;
        sent      = 0;
        text_left = 0;
        while (sent < n_items)
        begin
            start = 1'b0;
            if (text_left == 0)
            begin
                text_left = $urandom_range(30, 1);
                start     = 1'b1;
                tx_steady = ($urandom_range(3) == 0);
                rx_steady <= ($urandom_range(3) == 0);
            end
            else if ($urandom_range(99) < 4)
            begin
                start = 1'b1;
            end
            if (squeeze_midway && sent == n_items / 2)
                squeeze_req <= 1'b1;
            send_char(pick_text_char(), start);
            text_left--;
            sent++;
        end
    endtask

    initial
    begin
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: spacing runs, tabs from both spacing states, entities, extremes
        send_char(CH_SPACE, 1'b1);
        send_char(CH_SPACE, 1'b0);
        send_char(CH_SPACE, 1'b0);
        send_char(CH_TAB, 1'b0);
        send_char(CH_TAB, 1'b1);
        send_char(CH_LT, 1'b0);
        send_char(CH_GT, 1'b0);
        send_char(CH_SPACE, 1'b0);
        send_char(CH_AMP, 1'b0);
        send_char(CH_LF, 1'b0);
        send_char(CH_SPACE, 1'b0);
        send_char(16'hFFFF, 1'b0);
        send_char(16'h0000, 1'b0);
        send_char(16'h8000, 1'b0);
        send_char(16'h013C, 1'b0);
        send_char(16'h0061, 1'b1);

        // Whitespace passed through; a passed space still counts as a break
        write_escape(1'b0);
        send_char(CH_SPACE, 1'b1);
        send_char(CH_LF, 1'b0);
        send_char(CH_TAB, 1'b0);
        send_char(CH_GT, 1'b0);
        send_char(CH_SPACE, 1'b0);
        write_escape(1'b1);
        send_char(CH_SPACE, 1'b0);
        send_char(CH_TAB, 1'b0);

        // Random texts under both settings, with the long hold-off in the first
        send_texts(110, 1'b1);
        write_escape(1'b0);
        send_texts(80, 1'b0);
        write_escape(1'b1);
        send_texts(110, 1'b0);

        // Drain and settle
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
